@@ rtl/cht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cht_pkg;

   // Fixed field widths of the request and response channels
   localparam int ACTION_W = 3;
   localparam int KEY_W    = 32;
   localparam int ENTRY_W  = 16;
   localparam int RESULT_W = 17;

   // Bucket remainder unit: four dividend bits per cycle
   localparam int HASH_DIGIT = 4;
   localparam int HASH_STEPS = KEY_W / HASH_DIGIT;
   localparam int HASH_CNT_W = $clog2(HASH_STEPS);

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 3'd0,
      ACT_FIRST = 3'd1,
      ACT_NEXT  = 3'd2,
      ACT_REM   = 3'd3,
      ACT_CLEAN = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_ADD,
      ST_FIRST,
      ST_NEXT,
      ST_RM_HEAD,
      ST_WALK,
      ST_LINK,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

@@ rtl/cht_hash.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cht_hash #(
   parameter int BUCKETS = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [cht_pkg::KEY_W-1:0]  key,
   output logic                                   done,
   output logic [$clog2(BUCKETS)-1:0]             bucket
);

   localparam int RW = $clog2(BUCKETS);
   localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [cht_pkg::HASH_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [cht_pkg::KEY_W-1:0]       mag_ff, mag_in;
   logic [RW-1:0]                   rem_ff, rem_in;
   logic [cht_pkg::KEY_W-1:0]       key_abs;

   // |key| fits in 32 bits unsigned, the most negative key included
   assign key_abs = key[cht_pkg::KEY_W-1] ? (~key + 1'b1) : key;

   always_comb begin
      logic [cht_pkg::KEY_W-1:0] mag_v;
      logic [RW:0]               t_v;
      logic [RW-1:0]             rem_v;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      mag_v   = mag_ff;
      rem_v   = rem_ff;
      t_v     = '0;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = key_abs[RW-1:0];
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            mag_in  = key_abs;
            rem_in  = '0;
            cnt_in  = '0;
         end
      end else if (busy_ff) begin
         // restoring remainder, one dividend bit per inner step
         for (int i = 0; i < cht_pkg::HASH_DIGIT; i++) begin
            t_v   = {rem_v, mag_v[cht_pkg::KEY_W-1]};
            mag_v = mag_v << 1;
            if (t_v >= (RW+1)'(BUCKETS)) begin
               t_v = t_v - (RW+1)'(BUCKETS);
            end
            rem_v = t_v[RW-1:0];
         end
         mag_in = mag_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cht_pkg::HASH_CNT_W'(cht_pkg::HASH_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

`default_nettype wire

@@ rtl/chained_hash_index_table.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_action, req_key, req_entry
// rsp       out        rsp_valid/rsp_stall  rsp_result_index, rsp_found, rsp_status
//
// One item at a time. Add, get first and remove wait on the bucket remainder
// unit, which takes the low bits of |key| for a power-of-two BUCKETS and
// otherwise retires 4 key bits a cycle; remove then walks the chain, each
// node visited costing a link memory read; clean reruns the clearing pass.
// After reset a clearing pass writes empty into both memories, one address
// a cycle over max(BUCKETS, ENTRIES) addresses, with req_stall high throughout.
// A stalled response holds in the output register; the next request is taken
// meanwhile and completes once that register is free.

module chained_hash_index_table #(
   parameter int BUCKETS = 1024,
   parameter int ENTRIES = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [cht_pkg::ACTION_W-1:0]           req_action,
   input  wire logic signed [cht_pkg::KEY_W-1:0]       req_key,
   input  wire logic [cht_pkg::ENTRY_W-1:0]            req_entry,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic signed [cht_pkg::RESULT_W-1:0]         rsp_result_index,
   output logic                                        rsp_found,
   output logic                                        rsp_status
);

   localparam int EW   = $clog2(ENTRIES);
   localparam int HW   = $clog2(BUCKETS);
   localparam int DW   = EW + 1;              // stored link: all ones is empty
   localparam int MAXD = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
   localparam int CW   = $clog2(MAXD);
   localparam int SW   = $clog2(ENTRIES + 2);
   localparam logic [DW-1:0] NIL = '1;

   // Memories
   logic [DW-1:0] head_mem_ff [BUCKETS];
   logic [DW-1:0] link_mem_ff [ENTRIES];
   logic [DW-1:0] head_rdata_ff, link_rdata_ff;

   logic          head_we, link_we;
   logic [HW-1:0] head_wa, head_ra;
   logic [EW-1:0] link_wa, link_ra;
   logic [DW-1:0] head_wd, link_wd;

   // Control and working registers
   cht_pkg::state_type  state_ff, state_in;
   cht_pkg::action_type act_ff, act_in;
   logic [cht_pkg::ENTRY_W-1:0] entry_ff, entry_in;
   logic [HW-1:0]  bucket_ff, bucket_in;
   logic [DW-1:0]  cur_ff, cur_in;
   logic [DW-1:0]  prev_ff, prev_in;
   logic [SW-1:0]  steps_ff, steps_in;
   logic [CW-1:0]  sweep_ff, sweep_in;
   logic           clean_ff, clean_in;
   logic [DW-1:0]  res_index_ff, res_index_in;
   logic           res_found_ff, res_found_in;
   logic           res_status_ff, res_status_in;

   // Output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [cht_pkg::RESULT_W-1:0] rsp_index_ff, rsp_index_in;
   logic                                rsp_found_ff, rsp_found_in;
   logic                                rsp_status_ff, rsp_status_in;

   // Bucket remainder unit
   logic          hash_start;
   logic          hash_done;
   logic [HW-1:0] hash_bucket;
   logic          req_in_range;
   logic          out_free;

   cht_hash #(
      .BUCKETS (BUCKETS)
   ) u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_key),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   assign req_in_range = {1'b0, req_entry} < (cht_pkg::ENTRY_W+1)'(ENTRIES);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = (state_ff != cht_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      entry_in      = entry_ff;
      bucket_in     = bucket_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      sweep_in      = sweep_ff;
      clean_in      = clean_ff;
      res_index_in  = res_index_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      hash_start    = 1'b0;
      head_we       = 1'b0;
      head_wa       = bucket_ff;
      head_wd       = NIL;
      head_ra       = hash_bucket;
      link_we       = 1'b0;
      link_wa       = entry_ff[EW-1:0];
      link_wd       = NIL;
      link_ra       = req_entry[EW-1:0];

      // drop the response once the downstream side takes it
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_index_in  = rsp_index_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         cht_pkg::ST_CLEAR: begin
            // write empty into both memories, one address a cycle
            head_we  = ({1'b0, sweep_ff} < (CW+1)'(BUCKETS));
            head_wa  = sweep_ff[HW-1:0];
            link_we  = ({1'b0, sweep_ff} < (CW+1)'(ENTRIES));
            link_wa  = sweep_ff[EW-1:0];
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CW'(MAXD - 1)) begin
               sweep_in = '0;
               if (clean_ff) begin
                  clean_in = 1'b0;
                  state_in = cht_pkg::ST_RESP;
               end else begin
                  state_in = cht_pkg::ST_IDLE;
               end
            end
         end
         cht_pkg::ST_IDLE: begin
            if (req_valid) begin
               act_in        = cht_pkg::action_type'(req_action);
               entry_in      = req_entry;
               res_index_in  = NIL;
               res_found_in  = 1'b0;
               res_status_in = 1'b0;
               case (cht_pkg::action_type'(req_action))
                  cht_pkg::ACT_ADD, cht_pkg::ACT_REM: begin
                     if (req_in_range) begin
                        hash_start = 1'b1;
                        state_in   = cht_pkg::ST_HASH;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = cht_pkg::ST_RESP;
                     end
                  end
                  cht_pkg::ACT_FIRST: begin
                     hash_start = 1'b1;
                     state_in   = cht_pkg::ST_HASH;
                  end
                  cht_pkg::ACT_NEXT: begin
                     if (req_in_range) begin
                        state_in = cht_pkg::ST_NEXT;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = cht_pkg::ST_RESP;
                     end
                  end
                  cht_pkg::ACT_CLEAN: begin
                     clean_in = 1'b1;
                     state_in = cht_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = cht_pkg::ST_RESP;
                  end
               endcase
            end
         end
         cht_pkg::ST_HASH: begin
            if (hash_done) begin
               bucket_in = hash_bucket;
               case (act_ff)
                  cht_pkg::ACT_ADD:   state_in = cht_pkg::ST_ADD;
                  cht_pkg::ACT_FIRST: state_in = cht_pkg::ST_FIRST;
                  default:            state_in = cht_pkg::ST_RM_HEAD;
               endcase
            end
         end
         cht_pkg::ST_ADD: begin
            // push at the front: link := old head, head := entry
            link_we  = 1'b1;
            link_wa  = entry_ff[EW-1:0];
            link_wd  = head_rdata_ff;
            head_we  = 1'b1;
            head_wa  = bucket_ff;
            head_wd  = {1'b0, entry_ff[EW-1:0]};
            state_in = cht_pkg::ST_RESP;
         end
         cht_pkg::ST_FIRST: begin
            res_index_in = head_rdata_ff;
            state_in     = cht_pkg::ST_RESP;
         end
         cht_pkg::ST_NEXT: begin
            res_index_in = link_rdata_ff;
            state_in     = cht_pkg::ST_RESP;
         end
         cht_pkg::ST_RM_HEAD: begin
            cur_in   = head_rdata_ff;
            prev_in  = NIL;
            steps_in = '0;
            state_in = cht_pkg::ST_WALK;
         end
         cht_pkg::ST_WALK: begin
            // stop at the end of the chain or once the walk bound is spent
            if (cur_ff[DW-1] || (steps_ff > SW'(ENTRIES))) begin
               state_in = cht_pkg::ST_RESP;
            end else begin
               link_ra  = cur_ff[EW-1:0];
               state_in = cht_pkg::ST_LINK;
            end
         end
         cht_pkg::ST_LINK: begin
            if (cur_ff[EW-1:0] == entry_ff[EW-1:0]) begin
               // unlink: predecessor (or head) takes the successor
               res_found_in = 1'b1;
               if (prev_ff[DW-1]) begin
                  head_we = 1'b1;
                  head_wa = bucket_ff;
                  head_wd = link_rdata_ff;
               end else begin
                  link_we = 1'b1;
                  link_wa = prev_ff[EW-1:0];
                  link_wd = link_rdata_ff;
               end
               state_in = cht_pkg::ST_RESP;
            end else begin
               prev_in  = cur_ff;
               cur_in   = link_rdata_ff;
               steps_in = steps_ff + 1'b1;
               state_in = cht_pkg::ST_WALK;
            end
         end
         cht_pkg::ST_RESP: begin
            // hold until the output register is free, then load it
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = cht_pkg::RESULT_W'($signed(res_index_ff));
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               state_in      = cht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cht_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory ports: one write and one registered read each
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem_ff[head_wa] <= head_wd;
      end
      head_rdata_ff <= head_mem_ff[head_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem_ff[link_wa] <= link_wd;
      end
      link_rdata_ff <= link_mem_ff[link_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cht_pkg::ST_CLEAR;
         sweep_ff     <= '0;
         clean_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clean_ff     <= clean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      entry_ff      <= entry_in;
      bucket_ff     <= bucket_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      steps_ff      <= steps_in;
      res_index_ff  <= res_index_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;

   // Checks

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cht_pkg::ST_IDLE) |-> (!head_we && !link_we))
      else $error("memory written while idle");

   a_hash_in_state: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == cht_pkg::ST_HASH))
      else $error("bucket result outside hash wait");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_status))
      else $error("found reported together with an error status");

   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (&rsp_result_index))
      else $error("error response carries an index");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cht_pkg::ST_RESP && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished item not loaded into output register");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

// Scoreboard: a mirror of the bucket head and entry link memories, the
// answers still owed by the block, and what the stimulus needs to know about
// which entries currently sit in a chain.
class chain_table_scoreboard #(int BUCKETS = 1024, int ENTRIES = 4096);

   typedef struct packed {
      logic [16:0] index;
      logic        found;
      logic        status;
   } answer_t;

   int head_of [BUCKETS];
   int next_of [ENTRIES];

   bit                 linked [ENTRIES];
   logic signed [31:0] key_of [ENTRIES];
   int                 live [$];

   answer_t pending_answers [$];

   int requests_by_action [8];
   int out_of_range_count;
   int unlinked_count;
   int responses_checked;
   int mismatches;

   function new();
      clear_tables();
   endfunction

   function void clear_tables();
      foreach (head_of[i]) head_of[i] = -1;
      foreach (next_of[i]) next_of[i] = -1;
      foreach (linked[i]) linked[i] = 1'b0;
      live.delete();
   endfunction

   // Truncated remainder, then its magnitude, as the block hashes a key.
   function int bucket_of(logic signed [31:0] key);
      longint k;
      longint r;
      k = key;
      r = k % BUCKETS;
      if (r < 0) r = -r;
      return int'(r);
   endfunction

   function void mark_live(int e, logic signed [31:0] key);
      key_of[e] = key;
      if (!linked[e]) begin
         linked[e] = 1'b1;
         live.push_back(e);
      end
   endfunction

   function void forget_entry(int e);
      linked[e] = 1'b0;
      foreach (live[i]) begin
         if (live[i] == e) begin
            live.delete(i);
            break;
         end
      end
   endfunction

   // Visit at most ENTRIES + 1 entries from the head; a cycle ends the walk unfound.
   function bit unlink_entry(int b, int target);
      int cur;
      int prev;
      int steps;
      cur = head_of[b];
      prev = -1;
      steps = 0;
      while (cur >= 0 && cur < ENTRIES && steps <= ENTRIES) begin
         if (cur == target) begin
            if (prev == -1) head_of[b] = next_of[cur];
            else next_of[prev] = next_of[cur];
            return 1'b1;
         end
         prev = cur;
         cur = next_of[cur];
         steps++;
      end
      return 1'b0;
   endfunction

   function void note_request(logic [2:0] action, logic signed [31:0] key,
                              logic [15:0] entry);
      answer_t ans;
      bit      in_range;
      int      e;
      int      b;
      ans.index = '1;
      ans.found = 1'b0;
      ans.status = 1'b0;
      e = int'(entry);
      in_range = e < ENTRIES;
      requests_by_action[action]++;
      case (action)
         cht_pkg::ACT_ADD: begin
            if (!in_range) begin
               ans.status = 1'b1;
            end else begin
               b = bucket_of(key);
               next_of[e] = head_of[b];
               head_of[b] = e;
               mark_live(e, key);
            end
         end
         cht_pkg::ACT_FIRST: begin
            ans.index = 17'(head_of[bucket_of(key)]);
         end
         cht_pkg::ACT_NEXT: begin
            if (!in_range) ans.status = 1'b1;
            else ans.index = 17'(next_of[e]);
         end
         cht_pkg::ACT_REM: begin
            if (!in_range) begin
               ans.status = 1'b1;
            end else begin
               ans.found = unlink_entry(bucket_of(key), e);
               if (ans.found) begin
                  forget_entry(e);
                  unlinked_count++;
               end
            end
         end
         cht_pkg::ACT_CLEAN: begin
            clear_tables();
         end
         default: ;
      endcase
      if (ans.status) out_of_range_count++;
      pending_answers.push_back(ans);
   endfunction

   function void check_response(logic [16:0] index, logic found, logic status);
      answer_t exp;
      responses_checked++;
      if (pending_answers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] response with nothing owed: index %0d found %0b status %0b",
                     $time, $signed(index), found, status);
         return;
      end
      exp = pending_answers.pop_front();
      if (index !== exp.index || found !== exp.found || status !== exp.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] response %0d: index exp %0d got %0d, found exp %0b got %0b, status exp %0b got %0b",
                     $time, responses_checked, $signed(exp.index), $signed(index),
                     exp.found, found, exp.status, status);
      end
   endfunction

endclass

module tb;

   import cht_pkg::*;

   localparam int BUCKETS = 1024;
   localparam int ENTRIES = 4096;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int RANDOM_ITEMS  = 1675;
   localparam int HOLD_OFF      = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int KEY_POOL      = 20;

   // Slowest correct run: the clearing pass after reset, then per item the
   // longest sender gap and receiver stall, or the hold-off once, plus the
   // block's own time, which is longest for a clean and for a bounded walk
   // round a loop in a chain; the limit allows several times that total.
   localparam int CYCLE_LIMIT = 4_000_000;

   // Action codes the block leaves alone
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [2:0]          req_action = '0;
   logic signed [31:0]  req_key = '0;
   logic [15:0]         req_entry = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [16:0]  rsp_result_index;
   logic                rsp_found;
   logic                rsp_status;

   chain_table_scoreboard #(BUCKETS, ENTRIES) sb;

   logic signed [31:0] key_pool [KEY_POOL];

   bit steady = 1'b0;          // no idling on either side while set
   bit want_hold_off = 1'b0;   // raised once by the stimulus
   bit hold_off_done = 1'b0;   // raised by the receiver when it has held off

   int cycle_count = 0;

   chained_hash_index_table #(
      .BUCKETS(BUCKETS),
      .ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_key(req_key),
      .req_entry(req_entry),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_index(rsp_result_index),
      .rsp_found(rsp_found),
      .rsp_status(rsp_status)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Abandon the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d answers still owed",
                  cycle_count, sb.pending_answers.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int sender_gap();
      if (steady || (want_hold_off && !hold_off_done)) return 0;
      if ($urandom_range(0, 1) == 0) return 0;
      return idle_length();
   endfunction

   // Offer one request and hold it until the block takes the transfer. The
   // valid line is only lowered when a gap follows, so it never sees two
   // assignments in one step.
   task automatic send_request(logic [2:0] action, logic signed [31:0] key,
                               logic [15:0] entry);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key <= key;
      req_entry <= entry;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(action, key, entry);
   endtask

   // Keys in groups of four that land in one bucket: a base, the base moved
   // by a multiple of BUCKETS, and the negatives of both. The extremes follow.
   task automatic build_key_pool();
      logic signed [31:0] base;
      for (int g = 0; g < 4; g++) begin
         base = 32'($urandom_range(0, 32'h7FF0_0000));
         key_pool[4*g]     = base;
         key_pool[4*g + 1] = base + BUCKETS * $urandom_range(1, 999);
         key_pool[4*g + 2] = -base;
         key_pool[4*g + 3] = -key_pool[4*g + 1];
      end
      key_pool[16] = KEY_MIN;
      key_pool[17] = KEY_MAX;
      key_pool[18] = 32'sd0;
      key_pool[19] = -32'sd1;
   endtask

   task automatic run_directed();
      // empty bucket after the clearing pass; entry is ignored, even out of range
      send_request(ACT_FIRST, 32'sd0, 16'hFFFF);
      // build one chain in bucket 0, most negative key included, and one in 1023
      send_request(ACT_ADD, 32'sd0, 16'd0);
      send_request(ACT_ADD, 32'sd1024, 16'(ENTRIES - 1));
      send_request(ACT_ADD, KEY_MIN, 16'd7);
      send_request(ACT_ADD, KEY_MAX, 16'd100);
      send_request(ACT_ADD, -32'sd1023, 16'd200);
      // walk the bucket 0 chain to its end
      send_request(ACT_FIRST, 32'sd0, 16'd0);
      send_request(ACT_NEXT, 32'sd0, 16'd7);
      send_request(ACT_NEXT, 32'sd0, 16'(ENTRIES - 1));
      send_request(ACT_NEXT, 32'sd0, 16'd0);
      send_request(ACT_FIRST, 32'sd1023, 16'd0);
      // entries out of range: flagged, nothing changes
      send_request(ACT_ADD, 32'sd5, 16'(ENTRIES));
      send_request(ACT_NEXT, 32'sd0, 16'hFFFF);
      send_request(ACT_REM, 32'sd0, 16'hF000);
      // unlink from the middle, the head and the tail, then miss
      send_request(ACT_REM, 32'sd0, 16'(ENTRIES - 1));
      send_request(ACT_REM, 32'sd0, 16'd7);
      send_request(ACT_REM, -32'sd1023, 16'd100);
      send_request(ACT_REM, 32'sd0, 16'd5);
      // spare action codes
      send_request(ACT_SPARE_FIRST, 32'($urandom()), 16'($urandom()));
      send_request(ACT_SPARE_LAST, KEY_MIN, 16'hFFFF);
      // re-add the lone head: it now links to itself
      send_request(ACT_ADD, 32'sd0, 16'd0);
      send_request(ACT_NEXT, 32'sd0, 16'd0);
      // remove an absent entry: the walk runs round the loop until its bound
      send_request(ACT_REM, 32'sd0, 16'd9);
      send_request(ACT_CLEAN, 32'($urandom()), 16'($urandom()));
      send_request(ACT_FIRST, 32'sd0, 16'd0);
   endtask

   // Mostly well-formed traffic on chained entries: adds of free entries,
   // lookups and walks over live ones, removes with the key they were added
   // under. The rest is noise: stray keys, wrong keys, bad entries, re-adds.
   task automatic send_random_request();
      logic [2:0]         action;
      logic signed [31:0] key;
      logic [15:0]        entry;
      int                 roll;
      int                 e;
      roll = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      entry = 16'($urandom_range(0, ENTRIES - 1));
      if (roll < 30) begin
         action = ACT_ADD;
         if (roll == 0 && $urandom_range(0, 1) == 0 && sb.live.size() != 0) begin
            entry = 16'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
         end else begin
            do e = $urandom_range(0, ENTRIES - 1); while (sb.linked[e]);
            entry = 16'(e);
         end
         if ($urandom_range(0, 4) == 0) key = 32'($urandom());
      end else if (roll < 48) begin
         action = ACT_FIRST;
         if (roll >= 45) key = 32'($urandom());
         entry = 16'($urandom());
      end else if (roll < 63) begin
         action = ACT_NEXT;
         if (roll < 60 && sb.live.size() != 0)
            entry = 16'(sb.live[$urandom_range(0, sb.live.size() - 1)]);
      end else if (roll < 85) begin
         action = ACT_REM;
         if (roll < 80 && sb.live.size() != 0) begin
            e = sb.live[$urandom_range(0, sb.live.size() - 1)];
            entry = 16'(e);
            if (roll < 77) key = sb.key_of[e];
         end
      end else if (roll < 92) begin
         case ($urandom_range(0, 2))
            0: action = ACT_ADD;
            1: action = ACT_NEXT;
            default: action = ACT_REM;
         endcase
         key = 32'($urandom());
         entry = 16'($urandom_range(ENTRIES, 16'hFFFF));
      end else if (roll < 94) begin
         action = ACT_CLEAN;
         key = 32'($urandom());
         entry = 16'($urandom());
      end else begin
         action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
         key = 32'($urandom());
         entry = 16'($urandom());
      end
      send_request(action, key, entry);
   endtask

   // Receiver: random stalls, one long hold-off to back the block up, and
   // no stalls at all while the run is steady.
   initial begin : response_side
      int stretch;
      forever begin
         if (want_hold_off && !hold_off_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF) @(posedge clock);
            hold_off_done = 1'b1;
         end else if (steady || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            stretch = idle_length();
            repeat (stretch) @(posedge clock);
         end
      end
   end

   // Check every response transfer against the oldest answer owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_result_index, rsp_found, rsp_status);
   end

   initial begin : stimulus
      sb = new();
      build_key_pool();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // hold off the receiver while the sender keeps offering
      want_hold_off = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 600 && i < 800);
         send_random_request();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      // drain, then watch a while for anything unexpected
      while (sb.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d add, %0d get first, %0d get next, %0d remove, %0d clean and %0d spare-code requests, %0d with an entry out of range.",
               sb.requests_by_action[ACT_ADD], sb.requests_by_action[ACT_FIRST],
               sb.requests_by_action[ACT_NEXT], sb.requests_by_action[ACT_REM],
               sb.requests_by_action[ACT_CLEAN],
               sb.requests_by_action[5] + sb.requests_by_action[6] +
               sb.requests_by_action[7], sb.out_of_range_count);
      $display("Checked %0d responses (%0d removes unlinked an entry): %0d mismatches.",
               sb.responses_checked, sb.unlinked_count, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
